[rtl/fqmm_pkg.sv]
// Shared types and constants of the min/max fake quantizer.
package fqmm_pkg;

  // Configuration port geometry.
  localparam int CFG_INDEX_WIDTH = 2;
  localparam int CFG_DATA_WIDTH  = 32;

  // Width of the level code and of the level count.
  localparam int CODE_WIDTH = 16;

  // Register indexes.
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_RANGE_MIN  = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_RANGE_MAX  = 2'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_LEVEL_BITS = 2'd2;

  // Register reset values.
  localparam logic [31:0] RANGE_MIN_RESET  = 32'hFFFF_0000;
  localparam logic [30:0] RANGE_MAX_RESET  = 31'h0001_0000;
  localparam logic [4:0]  LEVEL_BITS_RESET = 5'd8;

  // Parameter derivation sequencer states.
  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_PREP = 9'b000000010,
    ST_ZNUM = 9'b000000100,
    ST_ZDIV = 9'b000001000,
    ST_MUL  = 9'b000010000,
    ST_LNUM = 9'b000100000,
    ST_LDIV = 9'b001000000,
    ST_HNUM = 9'b010000000,
    ST_HDIV = 9'b100000000
  } fqmm_state_t;

endpackage

[rtl/fake_quant_min_max.sv]
// Fake quantizer with min/max range: parameter sequencer and sample pipeline.
//
// Usage: write range_min (index 0), range_max (index 1) and level_bits (index 2)
// through cfg_wr/cfg_index/cfg_data while no transaction is in flight. Each
// write marks the derived parameters stale and busy rises; a sequencer then
// computes span, zero point and the nudged bounds with one shared bit-serial
// divider. The same happens after rst.
// A sample transaction is accepted at an edge with start high and busy low.
// Once busy is low a new sample may be accepted in every cycle.
// Each sample runs through a pipeline of VALUE_WIDTH + 22 register stages:
// clamp, multiply, a 16-stage divider by the span for the level code, a
// multiply back, and a (VALUE_WIDTH-1)-stage divider by the level count.
// The two pipelined dividers, one quotient bit per stage, make up most of them.
// The result appears on quantized_value, level_code and range_error for one
// cycle with done high at the end of the last stage; the receiver cannot
// stall, so results are never held or dropped.
// An empty range (range_max zero and range_min not negative) gives value 0, code 0 and
// range_error high. rst is synchronous and clears all valid and control bits.
module fake_quant_min_max #(
  parameter int VALUE_WIDTH    = 32,
  parameter int MAX_LEVEL_BITS = 16
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    start,
  output logic                                    busy,
  input  logic signed [VALUE_WIDTH-1:0]           sample_value,
  input  logic                                    cfg_wr,
  input  logic [fqmm_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
  input  logic [fqmm_pkg::CFG_DATA_WIDTH-1:0]     cfg_data,
  output logic                                    done,
  output logic signed [VALUE_WIDTH-1:0]           quantized_value,
  output logic [fqmm_pkg::CODE_WIDTH-1:0]         level_code,
  output logic                                    range_error
);

  localparam int VW  = VALUE_WIDTH;
  localparam int CDW = fqmm_pkg::CODE_WIDTH;
  localparam int RW  = (VW + 18 > 52) ? VW + 18 : 52;
  localparam int QW  = (VW - 1 > CDW) ? VW - 1 : CDW;
  localparam int CW  = $clog2(VW) + 1;
  localparam int PW1 = VW + CDW + 1;
  localparam int PW2 = 2 * CDW + 18;
  localparam int NB1 = CDW;
  localparam int NB2 = VW - 1;

  // Saturating fold of an unsigned quotient back to a signed value.
  function automatic logic [VW-1:0] fold_result(input logic neg, input logic ovf,
                                                input logic [VW-2:0] qt);
    logic [VW-1:0] mag;
    begin
      mag = {1'b0, qt};
      if (ovf) begin
        fold_result = neg ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
      end else begin
        fold_result = neg ? ~mag : mag;
      end
    end
  endfunction

  // Configuration registers.
  logic [31:0] range_min;
  logic [30:0] range_max;
  logic [4:0]  level_bits;

  always_ff @(posedge clk) begin
    if (rst) begin
      range_min  <= fqmm_pkg::RANGE_MIN_RESET;
      range_max  <= fqmm_pkg::RANGE_MAX_RESET;
      level_bits <= fqmm_pkg::LEVEL_BITS_RESET;
    end else if (cfg_wr) begin
      case (cfg_index)
        fqmm_pkg::CFG_RANGE_MIN:  range_min  <= cfg_data[31:0];
        fqmm_pkg::CFG_RANGE_MAX:  range_max  <= cfg_data[30:0];
        fqmm_pkg::CFG_LEVEL_BITS: level_bits <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // Derived parameters.
  fqmm_pkg::fqmm_state_t state;
  logic                  params_ready;
  logic [CDW-1:0]        q_reg;
  logic [31:0]           s_reg;
  logic [31:0]           negmn_reg;
  logic [CDW-1:0]        zp_reg;
  logic [47:0]           zps;
  logic [47:0]           qs;
  logic [RW-1:0]         c1_reg;
  logic signed [VW-1:0]  nlow;
  logic signed [VW-1:0]  nhigh;

  // Shared bit-serial divider of the sequencer.
  logic [RW-1:0] div_rem;
  logic [RW-1:0] div_den;
  logic [QW-1:0] div_quo;
  logic [CW-1:0] div_cnt;
  logic          div_neg;
  logic          div_ovf;

  // Effective bit count, level count, negated minimum and span.
  logic [4:0]     b_eff;
  logic [CDW-1:0] q_calc;
  logic [31:0]    negmn;
  logic [31:0]    s_calc;
  logic [47:0]    zprod;

  always_comb begin
    if (level_bits == 5'd0) begin
      b_eff = 5'd1;
    end else if (level_bits > 5'(MAX_LEVEL_BITS)) begin
      b_eff = 5'(MAX_LEVEL_BITS);
    end else begin
      b_eff = level_bits;
    end
    q_calc = CDW'((17'd1 << b_eff) - 17'd1);
    negmn  = range_min[31] ? (~range_min + 32'd1) : 32'd0;
    s_calc = {1'b0, range_max} + negmn;
    zprod  = negmn_reg * q_reg;
  end

  // One restoring step of the sequencer divider.
  logic          div_hit;
  logic [RW-1:0] rem_next;
  logic [QW-1:0] quo_next;

  assign div_hit  = div_rem >= div_den;
  assign rem_next = div_hit ? div_rem - div_den : div_rem;
  assign quo_next = {div_quo[QW-2:0], div_hit};

  // Signed numerator of a nudged bound, folded to a magnitude.
  logic [RW-1:0] num_m;
  logic          num_neg;
  logic [RW-1:0] num_u;
  logic          num_ovf;

  always_comb begin
    if (state == fqmm_pkg::ST_HNUM) begin
      num_m = (RW'(qs) << 1) - (RW'(zps) << 1) + RW'(q_reg);
    end else begin
      num_m = RW'(q_reg) - (RW'(zps) << 1);
    end
    num_neg = num_m[RW-1];
    num_u   = num_neg ? ~num_m : num_m;
    num_ovf = num_u >= (RW'(q_reg) << VW);
  end

  // Parameter derivation sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= fqmm_pkg::ST_IDLE;
      params_ready <= 1'b0;
    end else if (cfg_wr) begin
      state        <= fqmm_pkg::ST_IDLE;
      params_ready <= 1'b0;
    end else begin
      unique case (state)
        fqmm_pkg::ST_IDLE: begin
          if (!params_ready) begin
            state <= fqmm_pkg::ST_PREP;
          end
        end
        fqmm_pkg::ST_PREP: begin
          q_reg     <= q_calc;
          s_reg     <= s_calc;
          negmn_reg <= negmn;
          if (s_calc == 32'd0) begin
            zp_reg       <= '0;
            nlow         <= '0;
            nhigh        <= '0;
            c1_reg       <= '0;
            params_ready <= 1'b1;
            state        <= fqmm_pkg::ST_IDLE;
          end else begin
            state <= fqmm_pkg::ST_ZNUM;
          end
        end
        fqmm_pkg::ST_ZNUM: begin
          div_rem <= (RW'(zprod) << 1) + RW'(s_reg);
          div_den <= RW'(s_reg) << CDW;
          div_quo <= '0;
          div_cnt <= CW'(CDW);
          state   <= fqmm_pkg::ST_ZDIV;
        end
        fqmm_pkg::ST_ZDIV: begin
          div_rem <= rem_next;
          div_den <= div_den >> 1;
          div_quo <= quo_next;
          div_cnt <= div_cnt - CW'(1);
          if (div_cnt == CW'(1)) begin
            zp_reg <= quo_next[CDW-1:0];
            state  <= fqmm_pkg::ST_MUL;
          end
        end
        fqmm_pkg::ST_MUL: begin
          zps   <= zp_reg * s_reg;
          qs    <= q_reg * s_reg;
          state <= fqmm_pkg::ST_LNUM;
        end
        fqmm_pkg::ST_LNUM, fqmm_pkg::ST_HNUM: begin
          c1_reg  <= (RW'(zps) << 1) + RW'(s_reg);
          div_rem <= num_u;
          div_neg <= num_neg;
          div_ovf <= num_ovf;
          div_den <= RW'(q_reg) << (VW - 1);
          div_quo <= '0;
          div_cnt <= CW'(NB2);
          state   <= (state == fqmm_pkg::ST_LNUM) ? fqmm_pkg::ST_LDIV : fqmm_pkg::ST_HDIV;
        end
        fqmm_pkg::ST_LDIV, fqmm_pkg::ST_HDIV: begin
          div_rem <= rem_next;
          div_den <= div_den >> 1;
          div_quo <= quo_next;
          div_cnt <= div_cnt - CW'(1);
          if (div_cnt == CW'(1)) begin
            if (state == fqmm_pkg::ST_LDIV) begin
              nlow  <= fold_result(div_neg, div_ovf, quo_next[VW-2:0]);
              state <= fqmm_pkg::ST_HNUM;
            end else begin
              nhigh        <= fold_result(div_neg, div_ovf, quo_next[VW-2:0]);
              params_ready <= 1'b1;
              state        <= fqmm_pkg::ST_IDLE;
            end
          end
        end
        default: state <= fqmm_pkg::ST_IDLE;
      endcase
    end
  end

  assign busy = !params_ready;

  // Stage 1: clamp the sample to the nudged range.
  logic                 p1_vld;
  logic signed [VW-1:0] p1_x;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_vld <= 1'b0;
    end else begin
      p1_vld <= start && !busy;
    end
    if (sample_value < nlow) begin
      p1_x <= nlow;
    end else if (sample_value > nhigh) begin
      p1_x <= nhigh;
    end else begin
      p1_x <= sample_value;
    end
  end

  // Stage 2: scale by the level count.
  logic                  p2_vld;
  logic signed [PW1-1:0] p2_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      p2_vld <= 1'b0;
    end else begin
      p2_vld <= p1_vld;
    end
    p2_prod <= p1_x * $signed({1'b0, q_reg});
  end

  // Stage 3: code numerator 2*x*Q + (2*zp+1)*span.
  logic [RW-1:0] n_val;

  assign n_val = ({{(RW-PW1){p2_prod[PW1-1]}}, p2_prod} << 1) + c1_reg;

  // Pipelined divider by twice the span, one code bit per stage.
  logic [NB1:0]   d1_vld;
  logic [RW-1:0]  d1_rem [0:NB1];
  logic [CDW-1:0] d1_quo [0:NB1];
  logic           d1_neg [0:NB1];
  logic           d1_ovf [0:NB1];

  always_ff @(posedge clk) begin
    if (rst) begin
      d1_vld[0] <= 1'b0;
    end else begin
      d1_vld[0] <= p2_vld;
    end
    d1_rem[0] <= n_val;
    d1_quo[0] <= '0;
    d1_neg[0] <= n_val[RW-1];
    d1_ovf[0] <= n_val >= (RW'(s_reg) << (NB1 + 1));
  end

  for (genvar k = 0; k < NB1; k++) begin : g_div1
    logic hit;
    assign hit = d1_rem[k] >= (RW'(s_reg) << (NB1 - k));
    always_ff @(posedge clk) begin
      if (rst) begin
        d1_vld[k+1] <= 1'b0;
      end else begin
        d1_vld[k+1] <= d1_vld[k];
      end
      d1_rem[k+1] <= hit ? d1_rem[k] - (RW'(s_reg) << (NB1 - k)) : d1_rem[k];
      d1_quo[k+1] <= {d1_quo[k][CDW-2:0], hit};
      d1_neg[k+1] <= d1_neg[k];
      d1_ovf[k+1] <= d1_ovf[k];
    end
  end

  // Code stage: clamp the quotient to 0..Q.
  logic           p4_vld;
  logic [CDW-1:0] p4_code;

  always_ff @(posedge clk) begin
    if (rst) begin
      p4_vld <= 1'b0;
    end else begin
      p4_vld <= d1_vld[NB1];
    end
    if (d1_neg[NB1]) begin
      p4_code <= '0;
    end else if (d1_ovf[NB1] || d1_quo[NB1] > q_reg) begin
      p4_code <= q_reg;
    end else begin
      p4_code <= d1_quo[NB1];
    end
  end

  // Rescale stage: (code - zp) * span.
  logic                  p5_vld;
  logic [CDW-1:0]        p5_code;
  logic signed [PW2-1:0] p5_prod;
  logic signed [CDW:0]   p5_diff;

  assign p5_diff = $signed({1'b0, p4_code} - {1'b0, zp_reg});

  always_ff @(posedge clk) begin
    if (rst) begin
      p5_vld <= 1'b0;
    end else begin
      p5_vld <= p4_vld;
    end
    p5_code <= p4_code;
    p5_prod <= p5_diff * $signed({1'b0, s_reg});
  end

  // Value numerator 2*(code-zp)*span + Q, folded to a magnitude.
  logic [RW-1:0] m_val;
  logic          m_neg;
  logic [RW-1:0] m_u;

  assign m_val = ({{(RW-PW2){p5_prod[PW2-1]}}, p5_prod} << 1) + RW'(q_reg);
  assign m_neg = m_val[RW-1];
  assign m_u   = m_neg ? ~m_val : m_val;

  // Pipelined divider by twice the level count, one value bit per stage.
  logic [NB2:0]   d2_vld;
  logic [RW-1:0]  d2_rem  [0:NB2];
  logic [VW-2:0]  d2_quo  [0:NB2];
  logic [CDW-1:0] d2_code [0:NB2];
  logic           d2_neg  [0:NB2];
  logic           d2_ovf  [0:NB2];

  always_ff @(posedge clk) begin
    if (rst) begin
      d2_vld[0] <= 1'b0;
    end else begin
      d2_vld[0] <= p5_vld;
    end
    d2_rem[0]  <= m_u;
    d2_quo[0]  <= '0;
    d2_code[0] <= p5_code;
    d2_neg[0]  <= m_neg;
    d2_ovf[0]  <= m_u >= (RW'(q_reg) << VW);
  end

  for (genvar k = 0; k < NB2; k++) begin : g_div2
    logic hit;
    assign hit = d2_rem[k] >= (RW'(q_reg) << (NB2 - k));
    always_ff @(posedge clk) begin
      if (rst) begin
        d2_vld[k+1] <= 1'b0;
      end else begin
        d2_vld[k+1] <= d2_vld[k];
      end
      d2_rem[k+1]  <= hit ? d2_rem[k] - (RW'(q_reg) << (NB2 - k)) : d2_rem[k];
      d2_quo[k+1]  <= {d2_quo[k][VW-3:0], hit};
      d2_code[k+1] <= d2_code[k];
      d2_neg[k+1]  <= d2_neg[k];
      d2_ovf[k+1]  <= d2_ovf[k];
    end
  end

  // Output register; an empty range forces the error result.
  logic range_empty;

  assign range_empty = (s_reg == 32'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= d2_vld[NB2];
    end
    range_error <= range_empty;
    if (range_empty) begin
      quantized_value <= '0;
      level_code      <= '0;
    end else begin
      quantized_value <= fold_result(d2_neg[NB2], d2_ovf[NB2], d2_quo[NB2]);
      level_code      <= d2_code[NB2];
    end
  end

  // A register write always makes the block busy in the next cycle.
  a_cfg_busy: assert property (@(posedge clk) disable iff (rst) cfg_wr |=> busy)
    else $error("register write did not mark parameters stale");

  // The sequencer runs only while samples are held off.
  a_seq_busy: assert property (@(posedge clk) disable iff (rst)
    state != fqmm_pkg::ST_IDLE |-> busy)
    else $error("sequencer active while samples are accepted");

  // Items enter the pipeline only through an accepted transaction.
  a_entry: assert property (@(posedge clk) disable iff (rst)
    p1_vld |-> $past(start && !busy))
    else $error("pipeline entry without an accepted transaction");

  // A delivered code never exceeds the level count.
  a_code_range: assert property (@(posedge clk) disable iff (rst)
    done && !range_error |-> level_code <= q_reg)
    else $error("level code above level count");

endmodule

[verif/testbench.sv]
// Self-checking testbench for the min/max fake quantizer.
`timescale 1ns / 1ps

module testbench;

  localparam int VW = 32;
  localparam int MAXB = 16;
  localparam int PIPE_LAT = VW + 22;
  localparam int WATCHDOG_LIMIT = 20000;

  // An index past the register list; writes to it are ignored.
  localparam logic [fqmm_pkg::CFG_INDEX_WIDTH-1:0] CFG_UNMAPPED = 2'd3;

  typedef struct packed {
    logic signed [VW-1:0] value;
    logic [fqmm_pkg::CODE_WIDTH-1:0] code;
    logic err;
  } quant_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic signed [VW-1:0] sample_value = '0;
  logic cfg_wr = 1'b0;
  logic [fqmm_pkg::CFG_INDEX_WIDTH-1:0] cfg_index = '0;
  logic [fqmm_pkg::CFG_DATA_WIDTH-1:0] cfg_data = '0;
  logic done;
  logic signed [VW-1:0] quantized_value;
  logic [fqmm_pkg::CODE_WIDTH-1:0] level_code;
  logic range_error;

  // Shadow registers and derived quantizer parameters.
  logic [31:0] shadow_min;
  logic [30:0] shadow_max;
  logic [4:0] shadow_bits;
  bit derived_ok;
  longint nud_lo, nud_hi, span_q, levels_q, zero_q;

  quant_result_t expected_results[$];
  int fail_count = 0;
  int sent_count = 0;
  int checked_count = 0;
  int idle_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  fake_quant_min_max #(.VALUE_WIDTH(VW), .MAX_LEVEL_BITS(MAXB)) DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .sample_value(sample_value),
    .cfg_wr(cfg_wr), .cfg_index(cfg_index), .cfg_data(cfg_data), .done(done),
    .quantized_value(quantized_value), .level_code(level_code),
    .range_error(range_error)
  );

  function automatic longint floor_div(longint a, longint b);
    longint q;
    q = a / b;
    if ((a % b) != 0 && a < 0) q--;
    return q;
  endfunction

  function automatic longint sat_vw(longint v);
    longint hi, lo;
    hi = (longint'(1) << (VW - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // Recompute span, zero point and nudged bounds from the shadow registers.
  function automatic void derive_params();
    longint mn, b;
    b = shadow_bits;
    if (b < 1) b = 1;
    if (b > MAXB) b = MAXB;
    mn = longint'($signed(shadow_min));
    if (mn > 0) mn = 0;
    levels_q = (longint'(1) << b) - 1;
    span_q = longint'(shadow_max) - mn;
    derived_ok = 1'b1;
    if (span_q == 0) begin
      nud_lo = 0;
      nud_hi = 0;
      zero_q = 0;
      return;
    end
    zero_q = floor_div(2 * (-mn) * levels_q + span_q, 2 * span_q);
    if (zero_q < 0) zero_q = 0;
    if (zero_q > levels_q) zero_q = levels_q;
    nud_lo = sat_vw(floor_div(-2 * zero_q * span_q + levels_q, 2 * levels_q));
    nud_hi = sat_vw(floor_div(2 * (levels_q - zero_q) * span_q + levels_q, 2 * levels_q));
  endfunction

  function automatic quant_result_t quantize_sample(logic signed [VW-1:0] s);
    quant_result_t r;
    longint x, c;
    if (!derived_ok) derive_params();
    r = '0;
    if (span_q == 0) begin
      r.err = 1'b1;
      return r;
    end
    x = longint'(s);
    if (x < nud_lo) x = nud_lo;
    if (x > nud_hi) x = nud_hi;
    c = floor_div(2 * x * levels_q + (2 * zero_q + 1) * span_q, 2 * span_q);
    if (c < 0) c = 0;
    if (c > levels_q) c = levels_q;
    r.code = c[fqmm_pkg::CODE_WIDTH-1:0];
    r.value = VW'(sat_vw(floor_div(2 * (c - zero_q) * span_q + levels_q, 2 * levels_q)));
    return r;
  endfunction

  // Result checker: each done cycle is one result transaction.
  always @(posedge clk) begin
    quant_result_t exp_r;
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result: value %0d code %0d err %0d",
               quantized_value, level_code, range_error);
        fail_count++;
      end else begin
        exp_r = expected_results.pop_front();
        checked_count++;
        if (quantized_value !== exp_r.value) begin
          $error("quantized_value expected %0d actual %0d", exp_r.value, quantized_value);
          fail_count++;
        end
        if (level_code !== exp_r.code) begin
          $error("level_code expected %0d actual %0d", exp_r.code, level_code);
          fail_count++;
        end
        if (range_error !== exp_r.err) begin
          $error("range_error expected %0d actual %0d", exp_r.err, range_error);
          fail_count++;
        end
      end
    end
  end

  // Watchdog on cycles without an accepted transaction, a result, a reset or a register write.
  always @(posedge clk) begin
    if ((start && !busy) || done || rst || cfg_wr) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("fake_quant_min_max verification failed");
      $finish;
    end
  end

  // Send one sample, waiting for the block to accept it; start stays high
  // so that the next sample can follow in the very next cycle.
  task automatic send_sample(logic signed [VW-1:0] s);
    start <= 1'b1;
    sample_value <= s;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_results.push_back(quantize_sample(s));
    sent_count++;
  endtask

  task automatic idle_gap(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Register write, only while nothing is in flight.
  task automatic write_reg(logic [fqmm_pkg::CFG_INDEX_WIDTH-1:0] idx, logic [31:0] data);
    wait_drained();
    cfg_wr <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_wr <= 1'b0;
    if (idx == fqmm_pkg::CFG_RANGE_MIN) shadow_min = data;
    else if (idx == fqmm_pkg::CFG_RANGE_MAX) shadow_max = data[30:0];
    else if (idx == fqmm_pkg::CFG_LEVEL_BITS) shadow_bits = data[4:0];
    if (idx <= fqmm_pkg::CFG_LEVEL_BITS) derived_ok = 1'b0;
  endtask

  task automatic set_range(logic [31:0] mn, logic [30:0] mx, logic [4:0] b);
    write_reg(fqmm_pkg::CFG_RANGE_MIN, mn);
    write_reg(fqmm_pkg::CFG_RANGE_MAX, {1'b0, mx});
    write_reg(fqmm_pkg::CFG_LEVEL_BITS, {27'd0, b});
  endtask

  function automatic logic signed [VW-1:0] rand_sample();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $signed($urandom_range(0, 'h4_0000)) - 'sh2_0000;
      2: return 32'h8000_0000 + $urandom_range(0, 3);
      3: return 32'h7FFF_FFFF - $urandom_range(0, 3);
      default: return $signed($urandom_range(0, 'h100_0000)) - 'sh80_0000;
    endcase
  endfunction

  // Burst sender: random burst lengths, random gaps, some back-to-back.
  task automatic send_random(int n);
    int burst;
    while (n > 0) begin
      burst = $urandom_range(1, 40);
      while (burst > 0 && n > 0) begin
        send_sample(rand_sample());
        burst--;
        n--;
      end
      if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 12));
    end
  endtask

  // Samples at the extremes with the reset range.
  task automatic test_reset_range();
    send_sample(32'sh8000_0000);
    send_sample(32'sh7FFF_FFFF);
    send_sample(0);
    send_sample(32'sh0000_8000);
    send_sample(-32'sh0000_8000);
    send_sample(32'sh0001_0000);
  endtask

  // Special ranges: empty, positive minimum, bit counts out of range, and an unmapped write.
  task automatic test_special_ranges();
    set_range(32'h0, 31'h0, 5'd8);
    send_sample(32'sh1234_5678);
    send_sample(32'sh8000_0000);
    set_range(32'h0003_0000, 31'h0005_0000, 5'd4);
    send_sample(32'sh0002_0000);
    send_sample(-32'sh0001_0000);
    set_range(32'h8000_0000, 31'h7FFF_FFFF, 5'd0);
    send_sample(32'sh8000_0000);
    send_sample(32'sh7FFF_FFFF);
    set_range(32'hFFFE_0000, 31'h0000_0001, 5'd31);
    send_sample(32'sh0000_0001);
    send_sample(-32'sh0001_8000);
    set_range(32'h8000_0000, 31'h0, 5'd16);
    send_sample(32'sh0);
    send_sample(32'sh8000_0001);
    write_reg(CFG_UNMAPPED, 32'hFFFF_FFFF);
    send_sample(32'shC000_0000);
  endtask

  // Random phases over several settings, including extreme ones.
  task automatic test_random_phases();
    int phase;
    for (phase = 0; phase < 12; phase++) begin
      case (phase % 4)
        0: set_range($urandom_range(0, 'h7FFF_FFFF) | 32'h8000_0000,
                     31'($urandom_range(0, 'h7FFF_FFFF)), 5'($urandom_range(0, 31)));
        1: set_range(-$urandom_range(0, 'h8_0000), 31'($urandom_range(0, 'h8_0000)),
                     5'($urandom_range(1, 16)));
        2: set_range(32'h8000_0000, 31'h7FFF_FFFF, 5'd16);
        default: set_range(-$urandom_range(0, 3), 31'($urandom_range(0, 3)),
                           5'($urandom_range(1, 3)));
      endcase
      send_random(95);
    end
  endtask

  initial begin
    shadow_min = fqmm_pkg::RANGE_MIN_RESET;
    shadow_max = fqmm_pkg::RANGE_MAX_RESET;
    shadow_bits = fqmm_pkg::LEVEL_BITS_RESET;
    derived_ok = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_range();
    test_special_ranges();
    test_random_phases();
    wait_drained();
    idle_gap(PIPE_LAT + 10);
    $display("Sent %0d samples over 18 range settings; %0d results checked.",
             sent_count, checked_count);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("fake_quant_min_max verification clean");
    end else begin
      $display("fake_quant_min_max verification failed");
    end
    $finish;
  end

endmodule
